// File: design/ucd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder package
// Shared result types, lead byte constants and the decode helper functions.
// ----------------------------------------------------------------------------
package ucd_pkg;

  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;

  // Sequence lengths, as coded by a lead byte.
  localparam logic [2:0] SEQ_ONE   = 3'd1;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  // Lead byte masks and patterns.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
  } result_t;

  // All results that one input byte produces, head entry at index 0.
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

  // Number of bytes in the sequence that a byte opens.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = SEQ_ONE;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      len = SEQ_TWO;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      len = SEQ_THREE;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      len = SEQ_FOUR;
    end else begin
      len = SEQ_ONE;
    end
    return len;
  endfunction

  // A byte reported unchanged.
  function automatic logic [CP_W-1:0] raw_cp(input logic [7:0] b);
    return {{(CP_W-BYTE_W){1'b0}}, b};
  endfunction

  // Merge a sequence of the given length; trailing bytes give six bits each.
  function automatic logic [CP_W-1:0] assemble(input logic [2:0] len,
                                                input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2,
                                                input logic [7:0] b3);
    logic [CP_W-1:0] cp;
    case (len)
      SEQ_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
      SEQ_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      SEQ_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:   cp = raw_cp(b0);
    endcase
    return cp;
  endfunction

endpackage

// File: design/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a zero-terminated byte stream into code points, with an end marker
// after each terminator.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on in_valid / in_ready / in_byte. Results leave on
//   out_valid / out_ready with out_code_point, out_end_of_text and out_last;
//   out_last flags the final result that one input byte produced.
//   A byte that opens or only extends a pending sequence produces no result.
//   A byte is held in the input register; its results are then loaded into
//   the result queue once the queue can take them, and out_valid rises once
//   they are loaded. The first result transfers when the output side is
//   free. Throughput: one byte per cycle while the result queue can take
//   each byte's results. A terminator produces up to four results that
//   leave one per cycle while out_ready is high, and the input stalls behind
//   them until the last result of that bundle in the result queue transfers.
//   When the receiver stalls, the pending result stays on the output. Bytes
//   that produce no result still pass through the input register; the first
//   byte that produces a result waits there, and then in_ready drops.
//   Reset clears the input register, the result queue and the pending byte
//   count; the block starts with no sequence in progress.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_end_of_text,
  output logic        out_last
);
  import ucd_pkg::*;

  logic       in_full_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       load;
  logic       emit_free;
  bundle_t    bundle;

  // The held byte is decoded once the queue can take its results; a byte
  // with no results moves on regardless.
  assign advance  = in_full_r && ((bundle.count == '0) || emit_free);
  assign load     = advance && (bundle.count != '0);
  assign in_ready = !in_full_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  ucd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .bundle  (bundle)
  );

  ucd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .bundle          (bundle),
    .free            (emit_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_end_of_text (out_end_of_text),
    .out_last        (out_last)
  );

endmodule

// File: design/ucd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the pending lead and continuation bytes and turns one input byte
// into the bundle of results that it produces.
// ----------------------------------------------------------------------------
module ucd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output ucd_pkg::bundle_t bundle
);
  import ucd_pkg::*;

  logic [7:0] pend_r [3];
  logic [1:0] pend_cnt_r;
  logic [1:0] pend_cnt_nxt;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic [2:0] lead_len;
  logic [2:0] cnt_ext;
  logic       completing;
  logic [7:0] seq1;
  logic [7:0] seq2;

  assign lead_len = seq_len(pend_r[0]);
  assign cnt_ext  = {1'b0, pend_cnt_r};
  assign completing = ((cnt_ext + 3'd1) >= lead_len) || (pend_cnt_r == 2'd3);
  // The new byte sits right after the held bytes.
  assign seq1 = (pend_cnt_r == 2'd1) ? byte_in : pend_r[1];
  assign seq2 = (pend_cnt_r == 2'd2) ? byte_in : pend_r[2];

  // Result bundle and next pending state.
  always_comb begin
    bundle       = '0;
    pend_cnt_nxt = pend_cnt_r;
    wr_en        = 1'b0;
    wr_idx       = pend_cnt_r;
    if (byte_in != 8'd0) begin
      if (pend_cnt_r == 2'd0) begin
        if (seq_len(byte_in) == SEQ_ONE) begin
          bundle.count             = 3'd1;
          bundle.res[0].code_point = raw_cp(byte_in);
        end else begin
          wr_en        = 1'b1;
          pend_cnt_nxt = 2'd1;
        end
      end else if (completing) begin
        bundle.count             = 3'd1;
        bundle.res[0].code_point = assemble(cnt_ext + 3'd1, pend_r[0], seq1, seq2,
                                            byte_in);
        pend_cnt_nxt             = 2'd0;
      end else begin
        wr_en        = 1'b1;
        pend_cnt_nxt = pend_cnt_r + 2'd1;
      end
    end else begin
      // Terminator: the held lead is always incomplete, so it goes out raw;
      // only a two-byte lead in the second slot can still be decoded.
      pend_cnt_nxt = 2'd0;
      case (pend_cnt_r)
        2'd0: begin
          bundle.count              = 3'd1;
          bundle.res[0].end_of_text = 1'b1;
        end
        2'd1: begin
          bundle.count              = 3'd2;
          bundle.res[0].code_point  = raw_cp(pend_r[0]);
          bundle.res[1].end_of_text = 1'b1;
        end
        2'd2: begin
          bundle.count              = 3'd3;
          bundle.res[0].code_point  = raw_cp(pend_r[0]);
          bundle.res[1].code_point  = raw_cp(pend_r[1]);
          bundle.res[2].end_of_text = 1'b1;
        end
        2'd3: begin
          bundle.res[0].code_point = raw_cp(pend_r[0]);
          if (seq_len(pend_r[1]) == SEQ_TWO) begin
            bundle.count              = 3'd3;
            bundle.res[1].code_point  = assemble(SEQ_TWO, pend_r[1], pend_r[2],
                                                 8'd0, 8'd0);
            bundle.res[2].end_of_text = 1'b1;
          end else begin
            bundle.count              = 3'd4;
            bundle.res[1].code_point  = raw_cp(pend_r[1]);
            bundle.res[2].code_point  = raw_cp(pend_r[2]);
            bundle.res[3].end_of_text = 1'b1;
          end
        end
        default: begin
          bundle.count = 3'd0;
        end
      endcase
    end
  end

  // Pending byte store.
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      pend_r[wr_idx] <= byte_in;
    end
  end

  // Pending byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else if (step) begin
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_lead_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cnt_r != 2'd0) |-> (lead_len != SEQ_ONE))
    else $error("held first byte is not a multibyte lead");

  a_lead_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cnt_r != 2'd0) |-> (cnt_ext < lead_len))
    else $error("held sequence is already complete");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (byte_in == 8'd0)) |=> (pend_cnt_r == 2'd0))
    else $error("terminator left bytes pending");
`endif

endmodule

// File: design/ucd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 result emitter
// Holds one result bundle and hands its entries out one transfer at a time.
// ----------------------------------------------------------------------------
module ucd_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ucd_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [20:0]      out_code_point,
  output logic             out_end_of_text,
  output logic             out_last
);
  import ucd_pkg::*;

  result_t [MAX_RES-1:0] res_r;
  result_t [MAX_RES-1:0] res_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  pop;

  assign out_valid       = (cnt_r != '0);
  assign pop             = out_valid && out_ready;
  assign free            = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign out_code_point  = res_r[0].code_point;
  assign out_end_of_text = res_r[0].end_of_text;
  assign out_last        = (cnt_r == CNT_W'(1));

  // Load a new bundle or shift the queue by one after a transfer.
  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (load) begin
      res_nxt = bundle.res;
      cnt_nxt = bundle.count;
    end else if (pop) begin
      res_nxt = {result_t'('0), res_r[MAX_RES-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("bundle loaded over undelivered results");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("transfer did not retire exactly one result");

  a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_text) |-> out_last)
    else $error("end marker is not the final result of its byte");
`endif

endmodule
